// ===== rtl/ple_pkg.sv =====
// shared types and constants for the positional list engine
`timescale 1ns / 1ps

package ple_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SHIFT = 2'd1,
    ST_READ  = 2'd2
  } state_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

// ===== rtl/ple_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/positional_list_engine_top.sv =====
// top level of the positional list engine: sequencer around the entry memory
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY words held in one synchronous memory.
// A request is taken at a rising edge where start is high and busy is low;
// operation selects insert, delete or read at position, value is the word
// to insert. Each request gives exactly one result, shown for one cycle
// with done_o: status_o, read_value_o and entry_count_o (count afterwards).
// Insert and delete move the later entries one place through the memory,
// one read and one write per cycle; a request that moves entries reads
// each of them, writes back the last word read, then writes the new word
// (insert only) and updates the count as it shows its result. A read
// returns the registered memory word; a rejected request answers from idle.
// busy is low in the cycle that shows a result, so the next request can
// be taken then. The receiver cannot stall; results are never held.
// Reset empties the list at once, the memory contents are left as they
// are and only entries below the count are ever read.
module positional_list_engine_top #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation_i,
  input  logic [CNT_W-1:0]      position_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic                  done_o,
  output logic                  status_o,
  output logic [DATA_WIDTH-1:0] read_value_o,
  output logic [CNT_W-1:0]      entry_count_o
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  ple_pkg::state_e state_q, state_d;
  logic                  ins_q, ins_d;
  logic [ADDR_W-1:0]     pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [ADDR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic                  pend_q, pend_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  valid_q, valid_d;
  logic                  status_q, status_d;
  logic [DATA_WIDTH-1:0] rv_q, rv_d;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [CNT_W-1:0]      last_idx;
  logic [CNT_W-1:0]      ins_pos;
  logic [CNT_W-1:0]      del_pos;
  logic [CNT_W-1:0]      del_next;

  assign last_idx = count_q - ONE_CNT;
  assign ins_pos  = (position_i > count_q) ? count_q : position_i;
  assign del_pos  = (position_i > last_idx) ? last_idx : position_i;
  assign del_next = del_pos + ONE_CNT;

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ple_pkg::ST_IDLE;
      ins_q    <= 1'b0;
      rem_q    <= '0;
      pend_q   <= 1'b0;
      count_q  <= '0;
      valid_q  <= 1'b0;
      status_q <= ple_pkg::STATUS_OK;
      rv_q     <= '0;
    end else begin
      state_q  <= state_d;
      ins_q    <= ins_d;
      rem_q    <= rem_d;
      pend_q   <= pend_d;
      count_q  <= count_d;
      valid_q  <= valid_d;
      status_q <= status_d;
      rv_q     <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    val_q    <= val_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
  end

  always_comb begin
    state_d   = state_q;
    ins_d     = ins_q;
    pos_d     = pos_q;
    val_d     = val_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    rem_d     = rem_q;
    pend_d    = pend_q;
    count_d   = count_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    rv_d      = rv_q;
    ram_we    = 1'b0;
    ram_waddr = wr_ptr_q;
    ram_wdata = ram_rdata;
    ram_raddr = rd_ptr_q;

    case (state_q)
      ple_pkg::ST_IDLE: begin
        ram_raddr = position_i[ADDR_W-1:0];
        if (start) begin
          case (ple_pkg::op_e'(operation_i))
            ple_pkg::OP_INSERT: begin
              if (count_q == CAP_CNT) begin
                valid_d  = 1'b1;
                status_d = ple_pkg::STATUS_ERR;
                rv_d     = '0;
              end else begin
                ins_d    = 1'b1;
                pos_d    = ins_pos[ADDR_W-1:0];
                val_d    = value_i;
                rem_d    = count_q - ins_pos;
                rd_ptr_d = last_idx[ADDR_W-1:0];
                pend_d   = 1'b0;
                state_d  = ple_pkg::ST_SHIFT;
              end
            end
            ple_pkg::OP_DELETE: begin
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = ple_pkg::STATUS_ERR;
                rv_d     = '0;
              end else begin
                ins_d    = 1'b0;
                pos_d    = del_pos[ADDR_W-1:0];
                rem_d    = last_idx - del_pos;
                rd_ptr_d = del_next[ADDR_W-1:0];
                pend_d   = 1'b0;
                state_d  = ple_pkg::ST_SHIFT;
              end
            end
            ple_pkg::OP_READ: begin
              if (position_i < count_q) begin
                state_d = ple_pkg::ST_READ;
              end else begin
                valid_d  = 1'b1;
                status_d = ple_pkg::STATUS_ERR;
                rv_d     = '0;
              end
            end
            default: begin
              valid_d  = 1'b1;
              status_d = ple_pkg::STATUS_ERR;
              rv_d     = '0;
            end
          endcase
        end
      end
      ple_pkg::ST_SHIFT: begin
        // write back the word read in the previous cycle
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (rem_q != '0) begin
          pend_d   = 1'b1;
          wr_ptr_d = ins_q ? (rd_ptr_q + 1'b1) : (rd_ptr_q - 1'b1);
          rd_ptr_d = ins_q ? (rd_ptr_q - 1'b1) : (rd_ptr_q + 1'b1);
          rem_d    = rem_q - ONE_CNT;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          if (ins_q) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q;
            ram_wdata = val_q;
            count_d   = count_q + ONE_CNT;
          end else begin
            count_d = last_idx;
          end
          valid_d  = 1'b1;
          status_d = ple_pkg::STATUS_OK;
          rv_d     = '0;
          state_d  = ple_pkg::ST_IDLE;
        end
      end
      ple_pkg::ST_READ: begin
        valid_d  = 1'b1;
        status_d = ple_pkg::STATUS_OK;
        rv_d     = ram_rdata;
        state_d  = ple_pkg::ST_IDLE;
      end
      default: begin
        state_d = ple_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_q != ple_pkg::ST_IDLE);
  assign done_o        = valid_q;
  assign status_o      = status_q;
  assign read_value_o  = rv_q;
  assign entry_count_o = count_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("count above capacity");

  a_count_moves_with_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> done_o)
    else $error("count changed without a result");

  a_error_reads_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (read_value_o == '0))
    else $error("failed request returned data");

  a_write_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy)
    else $error("memory write while idle");
`endif

endmodule
